// ----- hw/rtl/hect_pkg.sv -----
// hect_pkg: shared constants, types and datapath command codes of the
// hashed event counter table. No dependencies; every other file imports it.
package hect_pkg;

    // Table geometry
    localparam int CAPACITY = 1024;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int USED_W   = SLOT_W + 1;
    localparam int IDX_W    = 10;
    localparam int TEST_W   = 16;
    localparam int WORD_W   = 64;
    localparam int HALF_W   = WORD_W / 2;

    // Hash constants
    localparam logic [WORD_W-1:0] HASH_MUL_A = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [WORD_W-1:0] HASH_MUL_B = 64'hbf58_476d_1ce4_e5b9;
    localparam int HASH_SHIFT_1 = 29;
    localparam int HASH_SHIFT_2 = 32;

    // Operation codes of an input transaction
    localparam logic OP_ACCUM = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Result status codes
    typedef enum logic [2:0] {
        STS_ACCUM  = 3'd0,
        STS_INSERT = 3'd1,
        STS_DROP   = 3'd2,
        STS_IGNORE = 3'd3,
        STS_READ   = 3'd4
    } t_status;

    // Commands from the controller to the datapath
    typedef enum logic [4:0] {
        DP_NOP,
        DP_CLR_INIT,
        DP_CLEAR,
        DP_CAPTURE,
        DP_MUL_LL,
        DP_MUL_LH,
        DP_MUL_HL,
        DP_MUL_END,
        DP_MIX1,
        DP_MIX2,
        DP_PROBE_RD,
        DP_NEXT,
        DP_UPDATE,
        DP_INSERT,
        DP_DROP,
        DP_IGNORE,
        DP_READ_RD,
        DP_READ_RES
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic op_read;
        logic addr_zero;
        logic rd_valid;
        logic rd_match;
        logic at_limit;
        logic pos_last;
    } t_dp_sts;

    // One slot of the table memory
    typedef struct packed {
        logic              valid;
        logic [TEST_W-1:0] test;
        logic [WORD_W-1:0] addr;
        logic [WORD_W-1:0] count;
    } t_slot;

endpackage

// ----- hw/rtl/hect_evt_if.sv -----
// hect_evt_if: input channel of the counter table (valid/ready plus event fields).
// Depends on hect_pkg for field widths.
interface hect_evt_if;
    import hect_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     op;
    logic signed [TEST_W-1:0] test_number;
    logic [WORD_W-1:0]        address;
    logic [WORD_W-1:0]        increment;
    logic [IDX_W-1:0]         slot_index;

    modport source (
        output valid, op, test_number, address, increment, slot_index,
        input  ready
    );
    modport sink (
        input  valid, op, test_number, address, increment, slot_index,
        output ready
    );
endinterface

// ----- hw/rtl/hect_res_if.sv -----
// hect_res_if: result channel of the counter table (valid/ready plus slot report).
// Depends on hect_pkg for field widths.
interface hect_res_if;
    import hect_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [2:0]               status;
    logic [IDX_W-1:0]         slot_position;
    logic                     entry_valid;
    logic signed [TEST_W-1:0] entry_test;
    logic [WORD_W-1:0]        entry_address;
    logic [WORD_W-1:0]        entry_count;

    modport source (
        output valid, status, slot_position, entry_valid, entry_test,
               entry_address, entry_count,
        input  ready
    );
    modport sink (
        input  valid, status, slot_position, entry_valid, entry_test,
               entry_address, entry_count,
        output ready
    );
endinterface

// ----- hw/rtl/hashed_event_counter_table_core.sv -----
// hashed_event_counter_table_core: event counter table keyed by (test number, address).
// Only one transaction is in flight at a time; a new event is accepted once the
// previous result has been handed to the result register. The hash runs 10 steps:
// two 4-step products on one shared 32x32 multiplier and two mix steps. Reset
// (synchronous, active low) starts a clearing pass over the slot memory; ready
// stays low until it ends.
// Depends on hect_pkg, hect_evt_if, hect_res_if, hect_ctrl, hect_dp.
module hashed_event_counter_table_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hect_evt_if.sink   i_evt,
    hect_res_if.source o_res
);
    import hect_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    in_ready;
    logic    out_valid;

    // Controller
    hect_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_evt.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_res.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Datapath
    hect_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_op            (i_evt.op),
        .i_test_number   (i_evt.test_number),
        .i_address       (i_evt.address),
        .i_increment     (i_evt.increment),
        .i_slot_index    (i_evt.slot_index),
        .o_status        (o_res.status),
        .o_slot_position (o_res.slot_position),
        .o_entry_valid   (o_res.entry_valid),
        .o_entry_test    (o_res.entry_test),
        .o_entry_address (o_res.entry_address),
        .o_entry_count   (o_res.entry_count)
    );

    assign i_evt.ready = in_ready;
    assign o_res.valid = out_valid;

    // One transaction at a time: no accept right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_evt.valid && i_evt.ready) |=> !i_evt.ready)
        else $error("input accepted while a transaction is in flight");

    // Table writes happen only when the result register can take the result
    a_write_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd == DP_UPDATE || cmd == DP_INSERT) |-> (!o_res.valid || o_res.ready))
        else $error("table written while the result register is blocked");

    // A new result only appears while the block is busy with its transaction
    a_result_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res.valid) |-> !$past(i_evt.ready))
        else $error("result produced without a transaction in flight");

    // Slot memory writes never land during an idle cycle
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_evt.ready |-> !(cmd == DP_UPDATE || cmd == DP_INSERT || cmd == DP_CLEAR))
        else $error("slot memory written while idle");

endmodule

// ----- hw/rtl/hect_ctrl.sv -----
// hect_ctrl: controller state machine of the counter table; sequences the
// hash, the probe and the result hand-off. Depends on hect_pkg.
module hect_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  hect_pkg::t_dp_sts i_sts,
    output hect_pkg::t_dp_cmd o_cmd
);
    import hect_pkg::*;

    typedef enum logic [3:0] {
        S_CLR_START,
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_MUL_LL,
        S_MUL_LH,
        S_MUL_HL,
        S_MUL_END,
        S_MIX1,
        S_MIX2,
        S_PROBE,
        S_CHECK,
        S_READ_RES
    } t_state;

    t_state  r_state, n_state;
    logic    r_out_valid;
    logic    r_second, n_second;
    logic    out_free;
    logic    emit;
    t_dp_cmd cmd;

    // The result register may take a new transaction when empty or draining
    assign out_free = !r_out_valid || i_out_ready;

    // Next state and datapath command
    always_comb begin
        n_state  = r_state;
        n_second = r_second;
        cmd      = DP_NOP;
        emit     = 1'b0;
        unique case (r_state)
            S_CLR_START: begin
                cmd     = DP_CLR_INIT;
                n_state = S_CLEAR;
            end
            S_CLEAR: begin
                cmd = DP_CLEAR;
                if (i_sts.pos_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd     = DP_CAPTURE;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                priority if (i_sts.op_read) begin
                    cmd     = DP_READ_RD;
                    n_state = S_READ_RES;
                end else if (i_sts.addr_zero) begin
                    if (out_free) begin
                        cmd     = DP_IGNORE;
                        emit    = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    cmd      = DP_MUL_LL;
                    n_second = 1'b0;
                    n_state  = S_MUL_LH;
                end
            end
            S_MUL_LL: begin
                cmd     = DP_MUL_LL;
                n_state = S_MUL_LH;
            end
            S_MUL_LH: begin
                cmd     = DP_MUL_LH;
                n_state = S_MUL_HL;
            end
            S_MUL_HL: begin
                cmd     = DP_MUL_HL;
                n_state = S_MUL_END;
            end
            S_MUL_END: begin
                cmd     = DP_MUL_END;
                n_state = r_second ? S_MIX2 : S_MIX1;
            end
            S_MIX1: begin
                cmd      = DP_MIX1;
                n_second = 1'b1;
                n_state  = S_MUL_LL;
            end
            S_MIX2: begin
                cmd     = DP_MIX2;
                n_state = S_PROBE;
            end
            S_PROBE: begin
                cmd     = DP_PROBE_RD;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                priority if (i_sts.rd_valid && !i_sts.rd_match) begin
                    cmd = DP_NEXT;
                end else if (out_free) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                    priority if (i_sts.rd_valid) begin
                        cmd = DP_UPDATE;
                    end else if (i_sts.at_limit) begin
                        cmd = DP_DROP;
                    end else begin
                        cmd = DP_INSERT;
                    end
                end
            end
            S_READ_RES: begin
                if (out_free) begin
                    cmd     = DP_READ_RES;
                    emit    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and the result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR_START;
            r_second    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_second <= n_second;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

// ----- hw/rtl/hect_dp.sv -----
// hect_dp: datapath of the counter table: input latch, shared 32x32 multiplier
// for the hash, slot memory with registered read, result register. Depends on hect_pkg.
module hect_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  hect_pkg::t_dp_cmd                  i_cmd,
    output hect_pkg::t_dp_sts                  o_sts,
    input  logic                               i_op,
    input  logic signed [hect_pkg::TEST_W-1:0] i_test_number,
    input  logic [hect_pkg::WORD_W-1:0]        i_address,
    input  logic [hect_pkg::WORD_W-1:0]        i_increment,
    input  logic [hect_pkg::IDX_W-1:0]         i_slot_index,
    output logic [2:0]                         o_status,
    output logic [hect_pkg::IDX_W-1:0]         o_slot_position,
    output logic                               o_entry_valid,
    output logic signed [hect_pkg::TEST_W-1:0] o_entry_test,
    output logic [hect_pkg::WORD_W-1:0]        o_entry_address,
    output logic [hect_pkg::WORD_W-1:0]        o_entry_count
);
    import hect_pkg::*;

    // Latched transaction
    logic                     r_op;
    logic signed [TEST_W-1:0] r_test;
    logic [WORD_W-1:0]        r_addr;
    logic [WORD_W-1:0]        r_inc;
    logic [SLOT_W-1:0]        r_idx;

    // Hash registers
    logic [WORD_W-1:0] r_x, r_y, r_prod, r_acc;
    logic [HALF_W-1:0] mul_a, mul_b;
    logic [WORD_W-1:0] mul_p;
    logic [WORD_W-1:0] mix_h, mix_h2, fin_h;

    // Table
    t_slot             mem [CAPACITY];
    t_slot             r_rd;
    t_slot             wdata;
    logic              mem_we, mem_re;
    logic [SLOT_W-1:0] rd_addr;
    logic [SLOT_W-1:0] r_pos;
    logic [USED_W-1:0] r_used;
    logic [WORD_W-1:0] upd_count;

    // Result register
    t_status           r_out_status;
    logic [SLOT_W-1:0] r_out_pos;
    logic              r_out_valid_e;
    logic [TEST_W-1:0] r_out_test;
    logic [WORD_W-1:0] r_out_addr;
    logic [WORD_W-1:0] r_out_count;

    // Select the halves for the shared multiplier
    always_comb begin
        mul_a = r_x[HALF_W-1:0];
        mul_b = r_y[HALF_W-1:0];
        unique case (i_cmd)
            DP_MUL_LH: mul_b = r_y[WORD_W-1:HALF_W];
            DP_MUL_HL: mul_a = r_x[WORD_W-1:HALF_W];
            default:   ;
        endcase
    end
    assign mul_p = WORD_W'(mul_a) * WORD_W'(mul_b);

    // Xorshift stages of the hash
    assign mix_h  = r_addr ^ r_acc;
    assign mix_h2 = mix_h ^ (mix_h >> HASH_SHIFT_1);
    assign fin_h  = r_acc ^ (r_acc >> HASH_SHIFT_2);

    assign upd_count = r_rd.count + r_inc;

    // Input latch, hash, probe position and result register
    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            DP_CLR_INIT: r_pos <= '0;
            DP_CLEAR:    r_pos <= r_pos + 1'b1;
            DP_CAPTURE: begin
                r_op   <= i_op;
                r_test <= i_test_number;
                r_addr <= i_address;
                r_inc  <= i_increment;
                r_idx  <= i_slot_index[SLOT_W-1:0];
                r_x    <= {{(WORD_W-TEST_W){i_test_number[TEST_W-1]}}, i_test_number};
                r_y    <= HASH_MUL_A;
            end
            DP_MUL_LL: r_prod <= mul_p;
            DP_MUL_LH: begin
                r_acc  <= r_prod;
                r_prod <= mul_p;
            end
            DP_MUL_HL: begin
                r_acc  <= r_acc + {r_prod[HALF_W-1:0], {HALF_W{1'b0}}};
                r_prod <= mul_p;
            end
            DP_MUL_END: r_acc <= r_acc + {r_prod[HALF_W-1:0], {HALF_W{1'b0}}};
            DP_MIX1: begin
                r_x <= mix_h2;
                r_y <= HASH_MUL_B;
            end
            DP_MIX2:    r_pos <= fin_h[SLOT_W-1:0];
            DP_NEXT:    r_pos <= r_pos + 1'b1;
            DP_READ_RD: r_pos <= r_idx;
            DP_UPDATE: begin
                r_out_status  <= STS_ACCUM;
                r_out_pos     <= r_pos;
                r_out_valid_e <= 1'b1;
                r_out_test    <= r_rd.test;
                r_out_addr    <= r_rd.addr;
                r_out_count   <= upd_count;
            end
            DP_INSERT: begin
                r_out_status  <= STS_INSERT;
                r_out_pos     <= r_pos;
                r_out_valid_e <= 1'b1;
                r_out_test    <= r_test;
                r_out_addr    <= r_addr;
                r_out_count   <= r_inc;
            end
            DP_DROP, DP_IGNORE: begin
                r_out_status  <= (i_cmd == DP_DROP) ? STS_DROP : STS_IGNORE;
                r_out_pos     <= '0;
                r_out_valid_e <= 1'b0;
                r_out_test    <= '0;
                r_out_addr    <= '0;
                r_out_count   <= '0;
            end
            DP_READ_RES: begin
                r_out_status  <= STS_READ;
                r_out_pos     <= r_pos;
                r_out_valid_e <= r_rd.valid;
                r_out_test    <= r_rd.valid ? r_rd.test  : '0;
                r_out_addr    <= r_rd.valid ? r_rd.addr  : '0;
                r_out_count   <= r_rd.valid ? r_rd.count : '0;
            end
            default: ;
        endcase
    end

    // Count occupied slots
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_cmd == DP_INSERT) begin
            r_used <= r_used + 1'b1;
        end
    end

    // Memory port controls
    always_comb begin
        mem_we  = 1'b0;
        mem_re  = 1'b0;
        rd_addr = r_pos;
        wdata   = '0;
        unique case (i_cmd)
            DP_CLEAR: mem_we = 1'b1;
            DP_UPDATE: begin
                mem_we      = 1'b1;
                wdata       = r_rd;
                wdata.count = upd_count;
            end
            DP_INSERT: begin
                mem_we = 1'b1;
                wdata  = '{valid: 1'b1, test: r_test, addr: r_addr, count: r_inc};
            end
            DP_PROBE_RD: mem_re = 1'b1;
            DP_NEXT: begin
                mem_re  = 1'b1;
                rd_addr = r_pos + 1'b1;
            end
            DP_READ_RD: begin
                mem_re  = 1'b1;
                rd_addr = r_idx;
            end
            default: ;
        endcase
    end

    // Write the slot at the probe position; register read data
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_pos] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rd <= mem[rd_addr];
        end
    end

    // Status toward the controller
    assign o_sts.op_read   = (r_op == OP_READ);
    assign o_sts.addr_zero = (r_addr == '0);
    assign o_sts.rd_valid  = r_rd.valid;
    assign o_sts.rd_match  = (r_rd.addr == r_addr) && (r_rd.test == r_test);
    assign o_sts.at_limit  = (r_used >= USED_W'(CAPACITY / 2));
    assign o_sts.pos_last  = &r_pos;

    assign o_status        = r_out_status;
    assign o_slot_position = IDX_W'(r_out_pos);
    assign o_entry_valid   = r_out_valid_e;
    assign o_entry_test    = r_out_test;
    assign o_entry_address = r_out_addr;
    assign o_entry_count   = r_out_count;

endmodule
